### hdl/spq_pkg.sv
// spq_pkg: shared types, sizes and codes for the sorted priority queue.
// No dependencies; compiled first.
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ENTRY_W  = 5;
   localparam int DATA_W   = 32;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [1:0]               status_type;

   // controller -> datapath
   typedef struct packed {
      logic       do_enq;
      logic       do_deq;
      logic       load;
      status_type status;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage

### hdl/spq_if.sv
// spq_req_if / spq_rsp_if: valid/ready channels of the priority queue.
// Depends on spq_pkg.
interface spq_req_if;
   import spq_pkg::*;
   logic     valid;
   logic     ready;
   logic     operation;
   data_type item_value;
   data_type item_priority;
   modport source (output valid, operation, item_value, item_priority, input ready);
   modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;
   logic               valid;
   logic               ready;
   status_type         status;
   data_type           removed_value;
   data_type           removed_priority;
   logic               head_valid;
   data_type           head_value;
   data_type           head_priority;
   logic [ENTRY_W-1:0] entry_count;
   modport source (output valid, status, removed_value, removed_priority, head_valid,
                   head_value, head_priority, entry_count, input ready);
   modport sink   (input valid, status, removed_value, removed_priority, head_valid,
                   head_value, head_priority, entry_count, output ready);
endinterface

### hdl/spq_dp.sv
// spq_dp: sorted shift-register store, entry count and response registers.
// Depends on spq_pkg; driven by spq_ctrl commands.
module spq_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  spq_pkg::dp_cmd_type         cmd,
   output spq_pkg::dp_stat_type        stat,
   input  spq_pkg::data_type           req_value,
   input  spq_pkg::data_type           req_priority,
   output spq_pkg::status_type         rsp_status,
   output spq_pkg::data_type           rsp_removed_value,
   output spq_pkg::data_type           rsp_removed_priority,
   output logic                        rsp_head_valid,
   output spq_pkg::data_type           rsp_head_value,
   output spq_pkg::data_type           rsp_head_priority,
   output logic [spq_pkg::ENTRY_W-1:0] rsp_entry_count
);
   import spq_pkg::*;

   data_type  slot_val_ff [CAPACITY];
   data_type  slot_pri_ff [CAPACITY];
   data_type  slot_val_in [CAPACITY];
   data_type  slot_pri_in [CAPACITY];
   data_type  up_val [CAPACITY];
   data_type  up_pri [CAPACITY];
   data_type  dn_val [CAPACITY];
   data_type  dn_pri [CAPACITY];
   logic [CAPACITY-1:0] le;
   logic [CAPACITY-1:0] prev_le;
   count_type count_ff, count_in;

   status_type         status_ff;
   data_type           rem_val_ff, rem_pri_ff, head_val_ff, head_pri_ff;
   logic               head_vld_ff;
   logic [ENTRY_W-1:0] entry_cnt_ff;

   assign stat.full  = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty = (count_ff == '0);

   // neighbor views of the store for shifting up (insert) and down (remove)
   always_comb begin
      up_val[0] = '0;
      up_pri[0] = '0;
      for (int i = 1; i < CAPACITY; i++) begin
         up_val[i] = slot_val_ff[i-1];
         up_pri[i] = slot_pri_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         dn_val[i] = slot_val_ff[i+1];
         dn_pri[i] = slot_pri_ff[i+1];
      end
      dn_val[CAPACITY-1] = slot_val_ff[CAPACITY-1];
      dn_pri[CAPACITY-1] = slot_pri_ff[CAPACITY-1];
   end

   // le is a prefix: held slots that stay in front of the new entry
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         le[i] = (CNT_W'(i) < count_ff) && (slot_pri_ff[i] <= req_priority);
      end
      prev_le = {le[CAPACITY-2:0], 1'b1};
   end

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         slot_val_in[i] = slot_val_ff[i];
         slot_pri_in[i] = slot_pri_ff[i];
         if (cmd.do_enq && !le[i]) begin
            if (prev_le[i]) begin
               slot_val_in[i] = req_value;
               slot_pri_in[i] = req_priority;
            end else begin
               slot_val_in[i] = up_val[i];
               slot_pri_in[i] = up_pri[i];
            end
         end else if (cmd.do_deq) begin
            slot_val_in[i] = dn_val[i];
            slot_pri_in[i] = dn_pri[i];
         end
      end
      if (cmd.do_enq) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.do_deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         slot_val_ff[i] <= slot_val_in[i];
         slot_pri_ff[i] <= slot_pri_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff    <= cmd.status;
         rem_val_ff   <= cmd.do_deq ? slot_val_ff[0] : '0;
         rem_pri_ff   <= cmd.do_deq ? slot_pri_ff[0] : '0;
         head_vld_ff  <= (count_in != '0);
         head_val_ff  <= (count_in != '0) ? slot_val_in[0] : '0;
         head_pri_ff  <= (count_in != '0) ? slot_pri_in[0] : '0;
         entry_cnt_ff <= ENTRY_W'(count_in);
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_removed_value    = rem_val_ff;
   assign rsp_removed_priority = rem_pri_ff;
   assign rsp_head_valid       = head_vld_ff;
   assign rsp_head_value       = head_val_ff;
   assign rsp_head_priority    = head_pri_ff;
   assign rsp_entry_count      = entry_cnt_ff;

endmodule

### hdl/spq_ctrl.sv
// spq_ctrl: handshake control and operation decode for the priority queue.
// Depends on spq_pkg; commands spq_dp.
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  spq_pkg::dp_stat_type stat,
   output spq_pkg::dp_cmd_type  cmd
);
   import spq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_HOLD = 1'b1;

   logic state_ff, state_in;
   logic accept;

   // the output register frees up in the same cycle it is taken
   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign rsp_valid = (state_ff == ST_HOLD);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.load   = accept;
      cmd.do_enq = 1'b0;
      cmd.do_deq = 1'b0;
      cmd.status = STATUS_DONE;
      case (req_operation)
         OP_ENQ: begin
            if (stat.full) begin
               cmd.status = STATUS_FULL;
            end else begin
               cmd.do_enq = accept;
            end
         end
         OP_DEQ: begin
            if (stat.empty) begin
               cmd.status = STATUS_EMPTY;
            end else begin
               cmd.do_deq = accept;
            end
         end
         default: begin
            cmd.status = STATUS_DONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = ST_HOLD;
      end else if (rsp_ready) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("loaded response not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.load)
      else $error("pending response overwritten");

   a_enq_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.do_enq |-> (!stat.full && cmd.status == STATUS_DONE))
      else $error("insert into full store");

   a_deq_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.do_deq |-> (!stat.empty && cmd.status == STATUS_DONE))
      else $error("remove from empty store");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_enq && cmd.do_deq))
      else $error("insert and remove in one cycle");

endmodule

### hdl/stable_priority_queue.sv
// stable_priority_queue: top level of the sorted, arrival-stable priority queue.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_dp.
//
//   channel  direction  transaction
//   req      in         operation, item_value, item_priority
//   rsp      out        status, removed_*, head_*, entry_count
//
// A request is executed in the cycle it is accepted: all 16 slots compare
// against the new priority in parallel and the whole store shifts at once.
// The response is registered and shown the next cycle; a new request is
// taken every cycle as long as rsp is drained (req_ready = !rsp_valid | rsp_ready).
// Synchronous reset empties the store; slot contents are not cleared.
module stable_priority_queue (
   input logic      clock,
   input logic      reset,
   spq_req_if.sink  req,
   spq_rsp_if.source rsp
);
   import spq_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   spq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_operation (req.operation),
      .req_ready     (req.ready),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   spq_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_value            (req.item_value),
      .req_priority         (req.item_priority),
      .rsp_status           (rsp.status),
      .rsp_removed_value    (rsp.removed_value),
      .rsp_removed_priority (rsp.removed_priority),
      .rsp_head_valid       (rsp.head_valid),
      .rsp_head_value       (rsp.head_value),
      .rsp_head_priority    (rsp.head_priority),
      .rsp_entry_count      (rsp.entry_count)
   );

endmodule

### tb/tb_stable_priority_queue.sv
// tb_stable_priority_queue: self-checking bench for the sorted priority queue.
// Depends on spq_pkg, spq_if and the stable_priority_queue RTL.
module tb_stable_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int RANDOM_OPS = 1950;
   localparam int IDLE_LIMIT = 2000;
   localparam int END_PAUSE  = 8;

   typedef struct packed {
      logic     operation;
      data_type item_value;
      data_type item_priority;
   } queue_op_type;

   typedef struct packed {
      status_type         status;
      data_type           removed_value;
      data_type           removed_priority;
      logic               head_valid;
      data_type           head_value;
      data_type           head_priority;
      logic [ENTRY_W-1:0] entry_count;
   } queue_outcome_type;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   stable_priority_queue DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   queue_op_type      op_backlog[$];
   queue_outcome_type expected_outcomes[$];
   int                mismatches = 0;

   // shadow copy of the sorted store, slot 0 is the head
   data_type shadow_values[CAPACITY];
   data_type shadow_priorities[CAPACITY];
   int       shadow_count = 0;

   function automatic queue_outcome_type apply_queue_op(queue_op_type op);
      queue_outcome_type outcome;
      int                pos;
      int                i;
      outcome = '0;
      if (op.operation == OP_ENQ) begin
         if (shadow_count >= CAPACITY) begin
            outcome.status = STATUS_FULL;
         end else begin
            // stable insert: go past every entry with priority <= new one
            pos = 0;
            while (pos < shadow_count &&
                   $signed(shadow_priorities[pos]) <= $signed(op.item_priority))
               pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_values[i]     = shadow_values[i-1];
               shadow_priorities[i] = shadow_priorities[i-1];
            end
            shadow_values[pos]     = op.item_value;
            shadow_priorities[pos] = op.item_priority;
            shadow_count++;
            outcome.status = STATUS_DONE;
         end
      end else begin
         if (shadow_count == 0) begin
            outcome.status = STATUS_EMPTY;
         end else begin
            outcome.status           = STATUS_DONE;
            outcome.removed_value    = shadow_values[0];
            outcome.removed_priority = shadow_priorities[0];
            for (i = 1; i < shadow_count; i++) begin
               shadow_values[i-1]     = shadow_values[i];
               shadow_priorities[i-1] = shadow_priorities[i];
            end
            shadow_count--;
         end
      end
      if (shadow_count > 0) begin
         outcome.head_valid    = 1'b1;
         outcome.head_value    = shadow_values[0];
         outcome.head_priority = shadow_priorities[0];
      end
      outcome.entry_count = shadow_count[ENTRY_W-1:0];
      return outcome;
   endfunction

   task automatic push_enqueue(data_type value, data_type priority_num);
      queue_op_type op;
      op.operation     = OP_ENQ;
      op.item_value    = value;
      op.item_priority = priority_num;
      op_backlog.push_back(op);
   endtask

   task automatic push_dequeue();
      queue_op_type op;
      op.operation     = OP_DEQ;
      op.item_value    = data_type'($urandom);
      op.item_priority = data_type'($urandom);
      op_backlog.push_back(op);
   endtask

   function automatic data_type pick_priority();
      int sel;
      sel = $urandom_range(0, 99);
      // narrow range half the time so ties are frequent
      if (sel < 50)
         return data_type'($urandom_range(0, 4)) - data_type'(2);
      else if (sel < 65) begin
         case ($urandom_range(0, 3))
            0: return data_type'(32'h8000_0000);
            1: return data_type'(32'h7fff_ffff);
            2: return data_type'(32'hffff_ffff);
            default: return data_type'(0);
         endcase
      end
      return data_type'($urandom);
   endfunction

   // ---------------- driver ----------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      queue_op_type op;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= $urandom_range(1, 24);
         gap_left      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            op.operation     = req_bus.operation;
            op.item_value    = req_bus.item_value;
            op.item_priority = req_bus.item_priority;
            expected_outcomes.push_back(apply_queue_op(op));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (op_backlog.size() > 0) begin
               op = op_backlog.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.operation     <= op.operation;
               req_bus.item_value    <= op.item_value;
               req_bus.item_priority <= op.item_priority;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- receiver back-pressure ----------------
   int rsp_taken  = 0;
   int hold_left  = 0;
   int pace_cycle = 0;
   int pace_mode  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            rsp_taken <= rsp_taken + 1;
         pace_cycle <= pace_cycle + 1;
         if (pace_cycle % 50 == 0)
            pace_mode <= $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.valid && rsp_bus.ready &&
                      (rsp_taken == 400 || rsp_taken == 1300)) begin
            // long hold-off: the pending response is not taken and the request side must stall
            hold_left     <= 120;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (pace_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= (pace_cycle % 8 != 7);
            endcase
         end
      end
   end

   // ---------------- monitor ----------------
   task automatic check_field(string field, longint expected, longint actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", field, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      queue_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatches++;
         end else begin
            want = expected_outcomes.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("removed_value", want.removed_value, rsp_bus.removed_value);
            check_field("removed_priority", want.removed_priority, rsp_bus.removed_priority);
            check_field("head_valid", want.head_valid, rsp_bus.head_valid);
            check_field("head_value", want.head_value, rsp_bus.head_value);
            check_field("head_priority", want.head_priority, rsp_bus.head_priority);
            check_field("entry_count", want.entry_count, rsp_bus.entry_count);
         end
      end
   end

   // ---------------- watchdog ----------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- stimulus and end of test ----------------
   initial begin
      int made;
      int phase_len;
      int enq_pct;
      int i;
      int op_total;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.operation     = OP_ENQ;
      req_bus.item_value    = '0;
      req_bus.item_priority = '0;
      rsp_bus.ready         = 1'b0;

      // directed: empty dequeue, extremes, ties, fill to full, overflow
      push_dequeue();
      push_enqueue(32'sh7fff_ffff, 0);
      push_enqueue(32'sh8000_0000, 0);
      push_enqueue(-1, 32'sh8000_0000);
      push_enqueue(0, 32'sh7fff_ffff);
      push_enqueue(32'sh5555_5555, -1);
      for (i = 0; i < 11; i++)
         push_enqueue((i % 2) ? 32'shaaaa_aaaa : i * 7 - 35, (i % 3) - 1);
      push_enqueue(12345, 32'sh8000_0000);
      for (i = 0; i < 6; i++)
         push_dequeue();

      // random: fill, drain and balanced phases
      made = 0;
      while (made < RANDOM_OPS) begin
         phase_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: enq_pct = 80;
            1: enq_pct = 20;
            default: enq_pct = 50;
         endcase
         for (i = 0; i < phase_len && made < RANDOM_OPS; i++) begin
            if ($urandom_range(1, 100) <= enq_pct)
               push_enqueue(data_type'($urandom), pick_priority());
            else
               push_dequeue();
            made++;
         end
      end
      op_total = op_backlog.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // every transaction sent must come back before the run ends
      while (rsp_taken < op_total)
         @(posedge clock);
      repeat (END_PAUSE) @(posedge clock);

      if (mismatches == 0 && expected_outcomes.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### files.f
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_dp.sv
hdl/spq_ctrl.sv
hdl/stable_priority_queue.sv
tb/tb_stable_priority_queue.sv
